// ===== rtl/keypad_decimal_adder_display_core_macros.svh =====
// Assertion macros shared by the keypad adder modules.
// Each macro takes a label, the clock, the active-low reset, the property terms and a message.
`ifndef KEYPAD_DECIMAL_ADDER_DISPLAY_CORE_MACROS_SVH
`define KEYPAD_DECIMAL_ADDER_DISPLAY_CORE_MACROS_SVH

`ifndef SYNTH

`define KDAD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define KDAD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define KDAD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define KDAD_ASSERT(label, clk, rst_n, prop, msg)

`define KDAD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)

`define KDAD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/kdad_pkg.sv =====
package kdad_pkg;

  typedef enum logic {
    MODE_DIGIT = 1'b0,
    MODE_ADD   = 1'b1
  } mode_e;

  // Command queue between the front and the back; the depth must be a power of two.
  localparam int unsigned CmdDepth = 2;
  localparam int unsigned CmdPtrW  = (CmdDepth > 1) ? $clog2(CmdDepth) : 1;
  localparam int unsigned CmdCntW  = $clog2(CmdDepth + 1);

  localparam int unsigned SegFields     = 6;
  localparam int unsigned DisplayDigits = 6;

  localparam logic [20:0] EntryModulus = 21'd1000000;
  localparam logic [20:0] TwiceModulus = 21'd2000000;
  localparam int unsigned EntryStep    = 100000;
  localparam int unsigned DecimalBase  = 10;

  localparam logic [19:0] Div10Mult  = 20'd838861;
  localparam int unsigned Div10Shift = 23;
  localparam logic [7:0]  KeyDivMult  = 8'd205;
  localparam int unsigned KeyDivShift = 11;
  localparam logic [6:0]  KeyRowWeight = 7'd7;

  localparam logic [7:0] SegBlank = 8'hFF;

  typedef struct packed {
    logic       is_add;
    logic [6:0] value;
  } cmd_t;

  typedef struct packed {
    logic [20:0] raw;
    logic        second;
  } res_t;

  typedef struct packed {
    logic [19:0]                shown;
    logic                       second;
    logic [19:0]                rest;
    logic [SegFields-1:0][7:0]  seg;
  } stage_t;

  function automatic logic [6:0] key_value(input logic [6:0] code);
    logic [14:0] prod;
    logic [3:0]  row;
    logic [6:0]  col;
    prod = 15'(code) * 15'(KeyDivMult);
    row  = 4'(prod >> KeyDivShift);
    col  = code - 7'(row) * 7'(DecimalBase);
    return 7'(row) * KeyRowWeight + col;
  endfunction

  function automatic logic [19:0] mod_display(input logic [20:0] x);
    logic [20:0] r;
    if (x >= TwiceModulus) begin
      r = x - TwiceModulus;
    end else if (x >= EntryModulus) begin
      r = x - EntryModulus;
    end else begin
      r = x;
    end
    return r[19:0];
  endfunction

  // The reciprocal is exact for every 20-bit value, so no correction step is needed.
  function automatic logic [19:0] div10(input logic [19:0] x);
    logic [39:0] prod;
    prod = 40'(x) * 40'(Div10Mult);
    return 20'(prod >> Div10Shift);
  endfunction

  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] code;
    unique case (digit)
      4'd0:    code = 8'hA0;
      4'd1:    code = 8'hBE;
      4'd2:    code = 8'h62;
      4'd3:    code = 8'h2A;
      4'd4:    code = 8'h3C;
      4'd5:    code = 8'h29;
      4'd6:    code = 8'h21;
      4'd7:    code = 8'hBA;
      4'd8:    code = 8'h20;
      4'd9:    code = 8'h28;
      default: code = SegBlank;
    endcase
    return code;
  endfunction

endpackage

// ===== rtl/kdad_front.sv =====
`include "keypad_decimal_adder_display_core_macros.svh"

module kdad_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic              mode_i,
  input  logic [6:0]        key_code_i,
  output logic              cmd_valid_o,
  output kdad_pkg::cmd_t    cmd_o,
  input  logic              cmd_pop_i
);

  kdad_pkg::cmd_t                     queue_q [kdad_pkg::CmdDepth];
  logic [kdad_pkg::CmdPtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [kdad_pkg::CmdPtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [kdad_pkg::CmdCntW-1:0]       count_q, count_d;
  logic                               wr;
  kdad_pkg::cmd_t                     cmd_in;

  assign full        = (count_q == kdad_pkg::CmdCntW'(kdad_pkg::CmdDepth));
  assign cmd_valid_o = (count_q != '0);
  assign wr          = push && !full;
  assign cmd_o       = queue_q[rd_ptr_q];

  assign cmd_in.is_add = (kdad_pkg::mode_e'(mode_i) == kdad_pkg::MODE_ADD);
  assign cmd_in.value  = kdad_pkg::key_value(key_code_i);

  always_comb begin
    wr_ptr_d = wr ? wr_ptr_q + kdad_pkg::CmdPtrW'(1) : wr_ptr_q;
    rd_ptr_d = cmd_pop_i ? rd_ptr_q + kdad_pkg::CmdPtrW'(1) : rd_ptr_q;
    count_d  = count_q + kdad_pkg::CmdCntW'(wr) - kdad_pkg::CmdCntW'(cmd_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      queue_q[wr_ptr_q] <= cmd_in;
    end
  end

  `KDAD_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= kdad_pkg::CmdCntW'(kdad_pkg::CmdDepth), "command queue count beyond depth")
  `KDAD_ASSERT_IMPL(a_pop_nonempty, clk_i, rst_ni, cmd_pop_i, count_q != '0, "command popped from empty queue")

endmodule

// ===== rtl/kdad_back.sv =====
`include "keypad_decimal_adder_display_core_macros.svh"

module kdad_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  input  kdad_pkg::cmd_t  cmd_i,
  input  logic            adv_i,
  output logic            cmd_pop_o,
  output logic            res_valid_o,
  output kdad_pkg::res_t  res_o
);

  logic [20:0] first_q, first_d;
  logic [19:0] second_q, second_d;
  logic        entry_q, entry_d;
  logic        fire;
  logic [19:0] base;
  logic [19:0] appended;

  // Shifting in a digit only needs the operand modulo one hundred thousand.
  function automatic logic [19:0] append_value(input logic [19:0] x, input logic [6:0] v);
    logic [19:0] low;
    logic [19:0] r;
    low = x;
    for (int k = 1; k < kdad_pkg::DecimalBase; k++) begin
      if (x >= 20'(k * kdad_pkg::EntryStep)) begin
        low = x - 20'(k * kdad_pkg::EntryStep);
      end
    end
    r = low * 20'(kdad_pkg::DecimalBase) + 20'(v);
    if (21'(r) >= kdad_pkg::EntryModulus) begin
      r = r - kdad_pkg::EntryModulus[19:0];
    end
    return r;
  endfunction

  assign fire        = cmd_valid_i && adv_i;
  assign cmd_pop_o   = fire;
  assign res_valid_o = fire;

  assign base     = entry_q ? second_q : kdad_pkg::mod_display(first_q);
  assign appended = append_value(base, cmd_i.value);

  always_comb begin
    first_d  = first_q;
    second_d = second_q;
    entry_d  = entry_q;
    if (fire) begin
      if (cmd_i.is_add) begin
        if (second_q == '0) begin
          entry_d = 1'b1;
        end else begin
          first_d  = first_q + 21'(second_q);
          second_d = '0;
          entry_d  = 1'b0;
        end
      end else if (entry_q) begin
        second_d = appended;
      end else begin
        first_d = 21'(appended);
      end
    end
    res_o.second = (second_d != '0);
    res_o.raw    = res_o.second ? 21'(second_d) : first_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q  <= '0;
      second_q <= '0;
      entry_q  <= 1'b0;
    end else begin
      first_q  <= first_d;
      second_q <= second_d;
      entry_q  <= entry_d;
    end
  end

  `KDAD_ASSERT(a_second_reduced, clk_i, rst_ni, 21'(second_q) < kdad_pkg::EntryModulus, "second operand not reduced")
  `KDAD_ASSERT_NEXT(a_add_clears, clk_i, rst_ni, fire && cmd_i.is_add && second_q != '0, second_q == '0 && !entry_q, "add did not clear second operand")

endmodule

// ===== rtl/kdad_fmt.sv =====
`include "keypad_decimal_adder_display_core_macros.svh"

module kdad_fmt (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            res_valid_i,
  input  kdad_pkg::res_t  res_i,
  output logic            adv_o,
  input  logic            pop,
  output logic            empty,
  output logic [19:0]     shown_value_o,
  output logic            showing_second_o,
  output logic [7:0]      seg_digit0_o,
  output logic [7:0]      seg_digit1_o,
  output logic [7:0]      seg_digit2_o,
  output logic [7:0]      seg_digit3_o,
  output logic [7:0]      seg_digit4_o,
  output logic [7:0]      seg_digit5_o
);

  localparam int unsigned LastStage = kdad_pkg::SegFields;

  kdad_pkg::res_t         raw_q;
  logic                   raw_vld_q;
  kdad_pkg::stage_t       stage_q [LastStage+1];
  kdad_pkg::stage_t       stage_d [LastStage+1];
  logic [LastStage:0]     vld_q;
  logic [LastStage:0]     vld_d;

  // The whole pipeline moves together; it halts only while the output word waits.
  assign adv_o = !vld_q[LastStage] || pop;
  assign empty = !vld_q[LastStage];

  always_comb begin
    logic [19:0] quo;
    logic [19:0] prod;
    logic [3:0]  dig;
    stage_d[0].shown  = kdad_pkg::mod_display(raw_q.raw);
    stage_d[0].second = raw_q.second;
    stage_d[0].rest   = stage_d[0].shown;
    stage_d[0].seg    = {kdad_pkg::SegFields{kdad_pkg::SegBlank}};
    for (int s = 0; s < LastStage; s++) begin
      quo  = kdad_pkg::div10(stage_q[s].rest);
      prod = quo * 20'(kdad_pkg::DecimalBase);
      dig  = 4'(stage_q[s].rest - prod);
      stage_d[s+1]      = stage_q[s];
      stage_d[s+1].rest = quo;
      stage_d[s+1].seg[s] = (s < kdad_pkg::DisplayDigits) ? kdad_pkg::seg_code(dig)
                                                           : kdad_pkg::SegBlank;
    end
    vld_d = {vld_q[LastStage-1:0], raw_vld_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_vld_q <= 1'b0;
      vld_q     <= '0;
    end else if (adv_o) begin
      raw_vld_q <= res_valid_i;
      vld_q     <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      raw_q <= res_i;
      for (int s = 0; s <= LastStage; s++) begin
        stage_q[s] <= stage_d[s];
      end
    end
  end

  assign shown_value_o    = stage_q[LastStage].shown;
  assign showing_second_o = stage_q[LastStage].second;
  assign seg_digit0_o     = stage_q[LastStage].seg[0];
  assign seg_digit1_o     = stage_q[LastStage].seg[1];
  assign seg_digit2_o     = stage_q[LastStage].seg[2];
  assign seg_digit3_o     = stage_q[LastStage].seg[3];
  assign seg_digit4_o     = stage_q[LastStage].seg[4];
  assign seg_digit5_o     = stage_q[LastStage].seg[5];

  `KDAD_ASSERT_NEXT(a_hold_on_stall, clk_i, rst_ni, !adv_o, $stable(vld_q) && $stable(raw_vld_q), "pipeline moved while stalled")
  `KDAD_ASSERT_IMPL(a_issue_on_adv, clk_i, rst_ni, res_valid_i, adv_o, "word issued into stalled pipeline")

endmodule

// ===== rtl/keypad_decimal_adder_display_core.sv =====
// Keypad decimal adder with seven-segment display codes.
// Input side: a queue port. A key event (mode_i, key_code_i) is taken at a rising edge
// with push high and full low. Digit events shift a digit into the operand being
// entered; add events start second entry or fold the second operand into the first.
// Result side: a queue port. While empty is low the oldest result word is on
// shown_value_o, showing_second_o and seg_digit0_o to seg_digit5_o (units first,
// active-low segments); it is taken at a rising edge with pop high and empty low.
// Every event gives exactly one result word, in order.
// An accepted event passes the command queue, the result register and then the splitter
// stages before empty falls. Throughput: one event per cycle while no result word waits;
// the operand registers in the back end update once per cycle and the six-stage digit
// splitter, one divide-by-ten multiplier per stage, follows behind them.
// When pop stays low the splitter pipeline freezes behind the waiting result word and
// the two-entry command queue keeps taking events until it fills.
// Reset clears both operands, second entry, the command queue and all valid flags.
module keypad_decimal_adder_display_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        mode_i,
  input  logic [6:0]  key_code_i,
  output logic        empty,
  input  logic        pop,
  output logic [19:0] shown_value_o,
  output logic        showing_second_o,
  output logic [7:0]  seg_digit0_o,
  output logic [7:0]  seg_digit1_o,
  output logic [7:0]  seg_digit2_o,
  output logic [7:0]  seg_digit3_o,
  output logic [7:0]  seg_digit4_o,
  output logic [7:0]  seg_digit5_o
);

  logic            cmd_valid;
  kdad_pkg::cmd_t  cmd;
  logic            cmd_pop;
  logic            res_valid;
  kdad_pkg::res_t  res;
  logic            adv;

  kdad_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .mode_i      (mode_i),
    .key_code_i  (key_code_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  kdad_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .adv_i       (adv),
    .cmd_pop_o   (cmd_pop),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  kdad_fmt u_fmt (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .res_valid_i      (res_valid),
    .res_i            (res),
    .adv_o            (adv),
    .pop              (pop),
    .empty            (empty),
    .shown_value_o    (shown_value_o),
    .showing_second_o (showing_second_o),
    .seg_digit0_o     (seg_digit0_o),
    .seg_digit1_o     (seg_digit1_o),
    .seg_digit2_o     (seg_digit2_o),
    .seg_digit3_o     (seg_digit3_o),
    .seg_digit4_o     (seg_digit4_o),
    .seg_digit5_o     (seg_digit5_o)
  );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
module tb;
  import kdad_pkg::*;

  localparam int unsigned RandomKeys = 2000;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned SettleCycles = 20;
  localparam int unsigned ShowModulus = 1000000;
  localparam int unsigned PhaseLen = 128;
  localparam int NumDirected = 25;
  localparam logic [7:0] DigitSegs [10] = '{
    8'hA0, 8'hBE, 8'h62, 8'h2A, 8'h3C, 8'h29, 8'h21, 8'hBA, 8'h20, 8'h28
  };

  typedef struct packed {
    logic [19:0]               shown;
    logic                      second;
    logic [SegFields-1:0][7:0] seg;
  } display_word_t;

  typedef struct packed {
    mode_e       mode;
    logic [6:0]  code;
    logic        typed;
    logic [19:0] shown;
    logic        second;
  } key_row_t;

  // Rows with typed set carry the display value that can be read off directly.
  key_row_t directed_rows [NumDirected] = '{
    '{MODE_DIGIT, 7'd0,   1'b1, 20'd0,      1'b0},
    '{MODE_DIGIT, 7'd99,  1'b1, 20'd72,     1'b0},
    '{MODE_DIGIT, 7'd127, 1'b1, 20'd811,    1'b0},
    '{MODE_DIGIT, 7'd9,   1'b1, 20'd8119,   1'b0},
    '{MODE_DIGIT, 7'd45,  1'b1, 20'd81223,  1'b0},
    '{MODE_DIGIT, 7'd10,  1'b1, 20'd812237, 1'b0},
    '{MODE_DIGIT, 7'd5,   1'b1, 20'd122375, 1'b0},
    '{MODE_ADD,   7'd127, 1'b1, 20'd122375, 1'b0},
    '{MODE_ADD,   7'd0,   1'b1, 20'd122375, 1'b0},
    '{MODE_DIGIT, 7'd0,   1'b1, 20'd122375, 1'b0},
    '{MODE_DIGIT, 7'd9,   1'b1, 20'd9,      1'b1},
    '{MODE_DIGIT, 7'd9,   1'b1, 20'd99,     1'b1},
    '{MODE_DIGIT, 7'd9,   1'b1, 20'd999,    1'b1},
    '{MODE_DIGIT, 7'd9,   1'b1, 20'd9999,   1'b1},
    '{MODE_DIGIT, 7'd9,   1'b1, 20'd99999,  1'b1},
    '{MODE_DIGIT, 7'd9,   1'b1, 20'd999999, 1'b1},
    '{MODE_DIGIT, 7'd9,   1'b1, 20'd999999, 1'b1},
    '{MODE_ADD,   7'd64,  1'b1, 20'd122374, 1'b0},
    '{MODE_ADD,   7'd0,   1'b1, 20'd122374, 1'b0},
    '{MODE_DIGIT, 7'd127, 1'b0, 20'd0,      1'b0},
    '{MODE_DIGIT, 7'd99,  1'b0, 20'd0,      1'b0},
    '{MODE_DIGIT, 7'd99,  1'b0, 20'd0,      1'b0},
    '{MODE_DIGIT, 7'd99,  1'b0, 20'd0,      1'b0},
    '{MODE_DIGIT, 7'd99,  1'b0, 20'd0,      1'b0},
    '{MODE_ADD,   7'd85,  1'b0, 20'd0,      1'b0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic        mode_i = MODE_DIGIT;
  logic [6:0]  key_code_i = 7'd0;
  logic        empty;
  logic        pop = 1'b1;
  logic [19:0] shown_value_o;
  logic        showing_second_o;
  logic [7:0]  seg_digit0_o;
  logic [7:0]  seg_digit1_o;
  logic [7:0]  seg_digit2_o;
  logic [7:0]  seg_digit3_o;
  logic [7:0]  seg_digit4_o;
  logic [7:0]  seg_digit5_o;

  logic [20:0]   first_acc = '0;
  logic [19:0]   second_acc = '0;
  logic          second_entry_on = 1'b0;
  key_row_t      keys_in_flight[$];
  display_word_t pending_words[$];
  int unsigned   keys_sent = 0;
  int unsigned   keys_taken = 0;
  int unsigned   adds_taken = 0;
  int unsigned   words_checked = 0;
  int unsigned   first_wraps = 0;
  int unsigned   mismatches = 0;
  int unsigned   pop_hold = 0;
  int unsigned   cycle_count = 0;

  keypad_decimal_adder_display_core u_dut (
    .clk_i,
    .rst_ni,
    .push,
    .full,
    .mode_i,
    .key_code_i,
    .empty,
    .pop,
    .shown_value_o,
    .showing_second_o,
    .seg_digit0_o,
    .seg_digit1_o,
    .seg_digit2_o,
    .seg_digit3_o,
    .seg_digit4_o,
    .seg_digit5_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic display_word_t word_for(logic [19:0] shown, logic second);
    display_word_t w;
    int unsigned   rest;
    w.shown = shown;
    w.second = second;
    rest = shown;
    for (int k = 0; k < SegFields; k++) begin
      w.seg[k] = (k < DisplayDigits) ? DigitSegs[rest % 10] : SegBlank;
      rest = rest / 10;
    end
    return w;
  endfunction

  function automatic int unsigned key_weight(logic [6:0] code);
    int unsigned c;
    c = code;
    return (c / 10) * 7 + c % 10;
  endfunction

  function automatic longint unsigned shift_in(longint unsigned x, int unsigned v);
    longint unsigned r;
    r = x * 10 + v;
    if (r >= ShowModulus) begin
      r = r % ShowModulus;
    end
    return r;
  endfunction

  function automatic display_word_t advance_adder(mode_e m, logic [6:0] code);
    logic [20:0] shown_raw;
    if (m == MODE_ADD) begin
      if (second_acc == '0) begin
        second_entry_on = 1'b1;
      end else begin
        if ({1'b0, first_acc} + 22'(second_acc) > 22'h1FFFFF) begin
          first_wraps++;
        end
        first_acc = first_acc + 21'(second_acc);
        second_acc = '0;
        second_entry_on = 1'b0;
      end
    end else if (second_entry_on) begin
      second_acc = 20'(shift_in(second_acc, key_weight(code)));
    end else begin
      first_acc = 21'(shift_in(first_acc, key_weight(code)));
    end
    shown_raw = (second_acc != '0) ? 21'(second_acc) : first_acc;
    return word_for(20'(shown_raw % ShowModulus), second_acc != '0);
  endfunction

  function automatic key_row_t make_row(mode_e m, logic [6:0] code);
    key_row_t row;
    row = '0;
    row.mode = m;
    row.code = code;
    return row;
  endfunction

  function automatic logic [6:0] digit_code();
    if ($urandom_range(0, 7) == 0) begin
      return 7'($urandom_range(100, 127));
    end
    return 7'($urandom_range(0, 99));
  endfunction

  task automatic record_key();
    display_word_t w;
    key_row_t      row;
    w = advance_adder(mode_e'(mode_i), key_code_i);
    row = keys_in_flight.pop_front();
    if (row.typed) begin
      w = word_for(row.shown, row.second);
    end
    pending_words.push_back(w);
    keys_taken++;
    if (mode_i == MODE_ADD) begin
      adds_taken++;
    end
  endtask

  task automatic field_check(string what, int unsigned want, int unsigned got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d (0x%0h), actual %0d (0x%0h)",
               $time, what, want, want, got, got);
      mismatches++;
    end
  endtask

  task automatic check_word();
    display_word_t             want;
    logic [SegFields-1:0][7:0] got_seg;
    got_seg = {seg_digit5_o, seg_digit4_o, seg_digit3_o,
               seg_digit2_o, seg_digit1_o, seg_digit0_o};
    if (pending_words.size() == 0) begin
      $display("%0t: unexpected result word, shown_value %0d", $time, shown_value_o);
      mismatches++;
    end else begin
      want = pending_words.pop_front();
      field_check("shown_value", want.shown, shown_value_o);
      field_check("showing_second", want.second, showing_second_o);
      for (int k = 0; k < SegFields; k++) begin
        field_check($sformatf("seg_digit%0d", k), want.seg[k], got_seg[k]);
      end
    end
    words_checked++;
  endtask

  always @(posedge clk_i) begin
    int unsigned stall;
    if (rst_ni && push && !full) begin
      record_key();
    end
    if (rst_ni && pop && !empty) begin
      check_word();
      stall = ((words_checked / PhaseLen) % 3 == 2) ? 0 : $urandom_range(0, 19);
      if (stall != 0) begin
        pop <= 1'b0;
      end
      pop_hold = stall;
    end else if (pop_hold != 0) begin
      pop_hold--;
      if (pop_hold == 0) begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("keypad_decimal_adder_display_core test failed");
      $finish;
    end
  end

  task automatic send_key(key_row_t row);
    int unsigned gap;
    gap = ((keys_sent / PhaseLen) % 3 == 1) ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    keys_in_flight.push_back(row);
    push <= 1'b1;
    mode_i <= row.mode;
    key_code_i <= row.code;
    do @(posedge clk_i); while (full);
    keys_sent++;
  endtask

  // Holds the input side until every word already sent has been checked.
  task automatic drain();
    push <= 1'b0;
    while (keys_in_flight.size() != 0 || pending_words.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  initial begin
    int unsigned n;
    bit          drained_mid;
    drained_mid = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int i = 0; i < NumDirected; i++) begin
      send_key(directed_rows[i]);
    end
    drain();
    // Most of the random part is whole sums: digits, add, digits, add.
    while (keys_sent < NumDirected + RandomKeys) begin
      if (!drained_mid && keys_sent >= NumDirected + RandomKeys / 2) begin
        drain();
        drained_mid = 1'b1;
      end
      if ($urandom_range(0, 9) < 8) begin
        n = $urandom_range(0, 3);
        repeat (n) send_key(make_row(MODE_DIGIT, digit_code()));
        send_key(make_row(MODE_ADD, 7'($urandom_range(0, 127))));
        n = $urandom_range(1, 7);
        repeat (n) send_key(make_row(MODE_DIGIT, digit_code()));
        send_key(make_row(MODE_ADD, 7'($urandom_range(0, 127))));
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          send_key(make_row(mode_e'($urandom_range(0, 1)), 7'($urandom_range(0, 127))));
        end
      end
    end
    drain();
    repeat (SettleCycles) @(posedge clk_i);
    $display("Checked %0d result words from %0d key events, %0d of them add keys.",
             words_checked, keys_taken, adds_taken);
    $display("The first operand wrapped past 21 bits %0d times; %0d faults were found.",
             first_wraps, mismatches);
    if (mismatches == 0) begin
      $display("keypad_decimal_adder_display_core test passed");
    end else begin
      $display("keypad_decimal_adder_display_core test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/kdad_pkg.sv
rtl/kdad_front.sv
rtl/kdad_back.sv
rtl/kdad_fmt.sv
rtl/keypad_decimal_adder_display_core.sv
bench/tb.sv
